// ----- sv/pce_pkg.sv -----
// shared types, constants and color expansion functions for the palette color expander
package pce_pkg;

    // bank geometry
    localparam int NUM_CHIPS        = 3;
    localparam int ENTRIES_PER_CHIP = 4096;
    localparam int PAL_DEPTH        = NUM_CHIPS * ENTRIES_PER_CHIP;
    localparam int SLOT_W           = $clog2(PAL_DEPTH);
    localparam int CHIP_IDX_W       = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;

    // fixed field widths
    localparam int ADDR_W  = 12;
    localparam int CHIP_W  = 2;
    localparam int WORD_W  = 16;
    localparam int INDEX_W = CHIP_W + ADDR_W;

    // command codes
    localparam logic [1:0] CMD_LATCH = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // color formats
    localparam logic [1:0] FMT_555_RED_LO = 2'd0;
    localparam logic [1:0] FMT_555_RED_HI = 2'd1;
    localparam logic [1:0] FMT_444_RED_LO = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W         = 1;
    localparam int         CFG_DATA_W        = 2;
    localparam logic [0:0] CFG_ADDRESS_SHIFT = 1'd0;
    localparam logic [0:0] CFG_COLOR_FORMAT  = 1'd1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CHIP_W-1:0] chip;
        logic [WORD_W-1:0] data;
    } pce_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]  read_data;
        logic               color_valid;
        logic [INDEX_W-1:0] color_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } pce_out_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pce_rgb_t;

    // 5-bit component to 8 bits
    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // 4-bit component to 8 bits
    function automatic logic [7:0] expand4(input logic [3:0] v);
        return {v, v};
    endfunction

    // unpack a palette word in the selected format
    function automatic pce_rgb_t color_expand(input logic [WORD_W-1:0] w,
                                              input logic [1:0]        fmt);
        pce_rgb_t c;
        case (fmt)
            FMT_444_RED_LO:
            begin
                c.red   = expand4(w[3:0]);
                c.green = expand4(w[7:4]);
                c.blue  = expand4(w[11:8]);
            end
            FMT_555_RED_HI:
            begin
                c.red   = expand5(w[14:10]);
                c.green = expand5(w[9:5]);
                c.blue  = expand5(w[4:0]);
            end
            default:
            begin
                c.red   = expand5(w[4:0]);
                c.green = expand5(w[9:5]);
                c.blue  = expand5(w[14:10]);
            end
        endcase
        return c;
    endfunction

endpackage

// ----- sv/palette_ram_color_expander_top.sv -----
// palette chip bank: address latches, palette ram and color expansion
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------
//   in      | input     | in_valid / in_stall  | in_item  (pce_in_t)
//   out     | output    | out_valid / out_stall| out_item (pce_out_t)
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// one beat per cycle sustained while out_stall is low and the sweep is done; a taken
// beat passes the middle stage, beside the registered read data of the single palette
// ram port, then the output register. after reset the ram is swept to zero one entry
// a cycle, with in_stall held high meanwhile; configuration writes are taken throughout.
// out_stall holds the output register; the middle stage then fills and in_stall rises.
module palette_ram_color_expander_top
    import pce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pce_in_t               in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pce_out_t              out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(PAL_DEPTH - 1);
    localparam logic [SLOT_W-1:0] ENTRIES_VAL = SLOT_W'(ENTRIES_PER_CHIP);

    // configuration registers
    logic       address_shift_reg;
    logic [1:0] color_format_reg;

    // per-chip address latches
    logic [ADDR_W-1:0] latch_reg [NUM_CHIPS];

    // palette ram and its registered read data
    logic [WORD_W-1:0] pal_mem [PAL_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // clearing sweep
    logic              clearing_reg;
    logic [SLOT_W-1:0] clr_slot_reg;

    // middle stage and output register
    logic     s1_valid_reg;
    logic     s1_rd_reg;
    pce_out_t s1_item_reg;
    logic     out_valid_reg;
    pce_out_t out_item_reg;
    pce_out_t out_item_next;

    logic              accept;
    logic              chip_ok;
    logic              addr_ok;
    logic [ADDR_W-1:0] cur_addr;
    logic [SLOT_W-1:0] slot;
    logic              wr_en;
    logic              rd_en;
    logic              latch_en;
    logic [ADDR_W-1:0] latch_val;
    logic              s1_go;
    pce_rgb_t          rgb;
    pce_out_t          s1_item_next;

    // handshake
    assign s1_go    = !out_valid_reg || !out_stall;
    assign in_stall = clearing_reg || (s1_valid_reg && !s1_go);
    assign accept   = in_valid && !in_stall;

    // decode target chip and current latched address
    always_comb
    begin
        chip_ok  = ({1'b0, in_item.chip} < (CHIP_W + 1)'(NUM_CHIPS));
        cur_addr = chip_ok ? latch_reg[in_item.chip[CHIP_IDX_W-1:0]] : '0;
        addr_ok  = ({1'b0, cur_addr} < (ADDR_W + 1)'(ENTRIES_PER_CHIP));
        slot     = SLOT_W'(in_item.chip) * ENTRIES_VAL + SLOT_W'(cur_addr);
        latch_val = address_shift_reg ? in_item.data[ADDR_W:1]
                                      : in_item.data[ADDR_W-1:0];
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        latch_en = 1'b0;
        case (in_item.cmd)
            CMD_LATCH: latch_en = accept && chip_ok;
            CMD_WRITE: wr_en    = accept && chip_ok && addr_ok;
            CMD_READ:  rd_en    = accept && chip_ok && addr_ok;
            default:   ;
        endcase
    end

    // color result for a write beat
    always_comb
    begin
        rgb          = color_expand(in_item.data, color_format_reg);
        s1_item_next = '0;
        if (wr_en)
        begin
            s1_item_next.color_valid = 1'b1;
            s1_item_next.color_index = {in_item.chip, cur_addr};
            s1_item_next.red         = rgb.red;
            s1_item_next.green       = rgb.green;
            s1_item_next.blue        = rgb.blue;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_shift_reg <= 1'b1;
            color_format_reg  <= FMT_555_RED_LO;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ADDRESS_SHIFT)
            begin
                address_shift_reg <= cfg_data[0];
            end
            if (cfg_index == CFG_COLOR_FORMAT)
            begin
                color_format_reg <= cfg_data;
            end
        end
    end

    // address latches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHIPS; i++)
            begin
                latch_reg[i] <= '0;
            end
        end
        else if (latch_en)
        begin
            latch_reg[in_item.chip[CHIP_IDX_W-1:0]] <= latch_val;
        end
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_slot_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_slot_reg <= clr_slot_reg + 1'b1;
            if (clr_slot_reg == LAST_SLOT)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // palette ram port
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            pal_mem[clr_slot_reg] <= '0;
        end
        else if (wr_en)
        begin
            pal_mem[slot] <= in_item.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= pal_mem[slot];
        end
    end

    // middle stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // middle stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= s1_item_next;
            s1_rd_reg   <= rd_en;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // read word merged from the ram into the middle stage beat
    always_comb
    begin
        out_item_next           = s1_item_reg;
        out_item_next.read_data = s1_rd_reg ? rd_data_reg : '0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_go)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- sv/pce_checker.sv -----
// port-level checks for the palette color expander and their bind
module pce_checker
    import pce_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input pce_out_t out_item
);

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output beat changed");

    // a beat never carries both a color and nonzero read data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.color_valid |-> out_item.read_data == '0)
    else $error("color beat with read data");

    // without a color all color fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.color_valid |->
            out_item.color_index == '0 && out_item.red == '0 &&
            out_item.green == '0 && out_item.blue == '0)
    else $error("color fields set on a beat without color");

    // coming out of reset the ram sweep blocks input and nothing is pending
    assert property (@(posedge clk)
        $rose(rst_n) |-> in_stall && !out_valid)
    else $error("input open or output pending right after reset");

endmodule

bind palette_ram_color_expander_top pce_checker u_pce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
